@@ rtl/adsda_pkg.sv @@
// shared widths, reset values, register indexes and types of the sample averager
package adsda_pkg;

   localparam int SPI_W      = 32;
   localparam int SHIFT_W    = 5;
   localparam int ADC_W      = 15;
   localparam int RATE_W     = 16;
   localparam int SUM_W      = 31;
   localparam int DIVR_W     = RATE_W + 1;
   localparam int AVG_W      = 15;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [SHIFT_W-1:0] SAMPLE_SHIFT_RST = '0;
   localparam logic [ADC_W-1:0]   ADC_MAX_RST      = 15'd16383;
   localparam logic [ADC_W-1:0]   ADC_MIN_RST      = '0;
   localparam logic [SHIFT_W-1:0] DIG_POS_RST      = '0;
   localparam logic [RATE_W-1:0]  RATE_RST         = 16'd2;

   localparam logic [AVG_W-1:0]   AVG_MAX  = '1;
   localparam logic [DIVR_W-1:0]  RATE_ZERO_WINDOW = 17'h10000;

   localparam logic [CSR_ADDR_W-1:0] REG_SAMPLE_SHIFT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ADC_MAX      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_ADC_MIN      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_DIG_POS      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_RATE         = 3'd4;

   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  dividend;
      logic [DIVR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [SPI_W-1:0] restore_bytes(input logic [SPI_W-1:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

endpackage

@@ rtl/adsda_ifs.sv @@
// beat channels of the sample averager: sample words, averages and register writes
interface adsda_req_if;
   logic                          valid;
   logic                          ready;
   logic [adsda_pkg::SPI_W-1:0]   spi_word;
   modport source (output valid, output spi_word, input ready);
   modport sink   (input valid, input spi_word, output ready);
endinterface

interface adsda_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [adsda_pkg::AVG_W-1:0]   average_value;
   logic                          digital_level;
   modport source (output valid, output average_value, output digital_level, input ready);
   modport sink   (input valid, input average_value, input digital_level, output ready);
endinterface

interface adsda_csr_if;
   logic                               valid;
   logic                               ready;
   logic [adsda_pkg::CSR_ADDR_W-1:0]   addr;
   logic [adsda_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ rtl/adsda_div.sv @@
// restoring divider, one quotient bit per cycle
module adsda_div (
   input  logic                     clock,
   input  logic                     reset,
   input  adsda_pkg::div_req_type   div_req,
   output adsda_pkg::div_rsp_type   div_rsp
);

   localparam int STEPS = adsda_pkg::SUM_W;
   localparam int CNT_W = $clog2(STEPS);
   localparam int REM_W = adsda_pkg::DIVR_W;

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [REM_W-1:0]              rem_ff, rem_in;
   logic [adsda_pkg::SUM_W-1:0]   quo_ff, quo_in;
   logic [adsda_pkg::DIVR_W-1:0]  dvs_ff, dvs_in;
   logic [REM_W:0]                rem_sh;
   logic [REM_W:0]                diff;
   logic                          borrow;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[adsda_pkg::SUM_W-1]};
      diff   = rem_sh - {1'b0, dvs_ff};
      borrow = rem_sh < {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = borrow ? rem_sh[REM_W-1:0] : diff[REM_W-1:0];
         quo_in = {quo_ff[adsda_pkg::SUM_W-2:0], ~borrow};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ rtl/adc_sample_decimating_averager.sv @@
// Decimating boxcar averager for byte-reversed ADC words. A sample is taken
// in one cycle and folded into the running sum in the next. A sample that
// closes a window also runs the 31-step restoring divider (one quotient bit
// per cycle) and loads the result register. The result register frees the
// input side, so a new sample is taken while the previous average waits to
// be read. Register writes are accepted in any cycle.
module adc_sample_decimating_averager (
   input  logic              clock,
   input  logic              reset,
   adsda_req_if.sink         req_bus,
   adsda_rsp_if.source       rsp_bus,
   adsda_csr_if.sink         csr_bus
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACC,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type                          state_ff, state_in;
   logic [adsda_pkg::SHIFT_W-1:0]      shift_ff, shift_in;
   logic [adsda_pkg::ADC_W-1:0]        max_ff, max_in;
   logic [adsda_pkg::ADC_W-1:0]        min_ff, min_in;
   logic [adsda_pkg::SHIFT_W-1:0]      dpos_ff, dpos_in;
   logic [adsda_pkg::RATE_W-1:0]       rate_ff, rate_in;
   logic [adsda_pkg::SUM_W-1:0]        sum_ff, sum_in;
   logic [adsda_pkg::RATE_W-1:0]       count_ff, count_in;
   logic [adsda_pkg::SPI_W-1:0]        raw_ff, raw_in;
   logic                               pend_dig_ff, pend_dig_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [adsda_pkg::AVG_W-1:0]        avg_ff, avg_in;
   logic                               dig_ff, dig_in;

   logic [adsda_pkg::ADC_W-1:0]        mask;
   logic [adsda_pkg::SPI_W-1:0]        shifted;
   logic [adsda_pkg::ADC_W-1:0]        masked;
   logic [adsda_pkg::ADC_W-1:0]        val;
   logic [adsda_pkg::SUM_W-1:0]        sum_new;
   logic [adsda_pkg::DIVR_W-1:0]       count_new;
   logic [adsda_pkg::DIVR_W-1:0]       rate_eff;
   logic                               close_win;
   logic                               req_take;
   logic                               out_free;
   adsda_pkg::div_req_type             div_req;
   adsda_pkg::div_rsp_type             div_rsp;

   adsda_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ones up to the top set bit of full scale
   always_comb begin
      for (int i = 0; i < adsda_pkg::ADC_W; i++) begin
         mask[i] = |(max_ff >> i);
      end
   end

   always_comb begin
      shifted   = raw_ff >> shift_ff;
      masked    = shifted[adsda_pkg::ADC_W-1:0] & mask;
      val       = (masked < min_ff) ? '0 : masked - min_ff;
      sum_new   = sum_ff + adsda_pkg::SUM_W'(val);
      count_new = {1'b0, count_ff} + 1'b1;
      rate_eff  = (rate_ff == '0) ? adsda_pkg::RATE_ZERO_WINDOW : {1'b0, rate_ff};
      close_win = count_new >= rate_eff;

      div_req.start    = (state_ff == ST_ACC) && close_win;
      div_req.dividend = sum_new;
      div_req.divisor  = rate_eff;

      req_take = req_bus.valid && (state_ff == ST_IDLE);
      out_free = !rsp_valid_ff || rsp_bus.ready;

      state_in     = state_ff;
      shift_in     = shift_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      dpos_in      = dpos_ff;
      rate_in      = rate_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      raw_in       = raw_ff;
      pend_dig_in  = pend_dig_ff;
      avg_in       = avg_ff;
      dig_in       = dig_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      if (csr_bus.valid) begin
         unique case (csr_bus.addr)
            adsda_pkg::REG_SAMPLE_SHIFT: shift_in = csr_bus.data[adsda_pkg::SHIFT_W-1:0];
            adsda_pkg::REG_ADC_MAX:      max_in   = csr_bus.data[adsda_pkg::ADC_W-1:0];
            adsda_pkg::REG_ADC_MIN:      min_in   = csr_bus.data[adsda_pkg::ADC_W-1:0];
            adsda_pkg::REG_DIG_POS:      dpos_in  = csr_bus.data[adsda_pkg::SHIFT_W-1:0];
            adsda_pkg::REG_RATE:         rate_in  = csr_bus.data[adsda_pkg::RATE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               raw_in   = adsda_pkg::restore_bytes(req_bus.spi_word);
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (close_win) begin
               sum_in      = '0;
               count_in    = '0;
               pend_dig_in = raw_ff[dpos_ff];
               state_in    = ST_DIV;
            end else begin
               sum_in   = sum_new;
               count_in = count_new[adsda_pkg::RATE_W-1:0];
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               // saturate quotients above full output range
               avg_in       = (|div_rsp.quotient[adsda_pkg::SUM_W-1:adsda_pkg::AVG_W])
                              ? adsda_pkg::AVG_MAX
                              : div_rsp.quotient[adsda_pkg::AVG_W-1:0];
               dig_in       = pend_dig_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shift_ff     <= adsda_pkg::SAMPLE_SHIFT_RST;
         max_ff       <= adsda_pkg::ADC_MAX_RST;
         min_ff       <= adsda_pkg::ADC_MIN_RST;
         dpos_ff      <= adsda_pkg::DIG_POS_RST;
         rate_ff      <= adsda_pkg::RATE_RST;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shift_ff     <= shift_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         dpos_ff      <= dpos_in;
         rate_ff      <= rate_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      raw_ff      <= raw_in;
      pend_dig_ff <= pend_dig_in;
      avg_ff      <= avg_in;
      dig_ff      <= dig_in;
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign csr_bus.ready         = 1'b1;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.average_value = avg_ff;
   assign rsp_bus.digital_level = dig_ff;

endmodule

@@ tb/tb_adc_sample_decimating_averager.sv @@
// testbench of the decimating sample averager: directed and random beats against a scoreboard
typedef struct packed {
   logic [adsda_pkg::AVG_W-1:0] avg_value;
   logic                        dig_level;
} average_beat_type;

function automatic logic [adsda_pkg::SPI_W-1:0] swap_bytes(
   input logic [adsda_pkg::SPI_W-1:0] w);
   return {w[7:0], w[15:8], w[23:16], w[31:24]};
endfunction

class boxcar_tracker;
   logic [adsda_pkg::SHIFT_W-1:0] shift;
   logic [adsda_pkg::ADC_W-1:0]   full_scale;
   logic [adsda_pkg::ADC_W-1:0]   offset;
   logic [adsda_pkg::SHIFT_W-1:0] dig_pos;
   logic [adsda_pkg::RATE_W-1:0]  rate;
   logic [adsda_pkg::SUM_W-1:0]   sum;
   logic [adsda_pkg::RATE_W-1:0]  count;
   average_beat_type              expected_q[$];
   int                            errors;

   function new();
      shift      = adsda_pkg::SAMPLE_SHIFT_RST;
      full_scale = adsda_pkg::ADC_MAX_RST;
      offset     = adsda_pkg::ADC_MIN_RST;
      dig_pos    = adsda_pkg::DIG_POS_RST;
      rate       = adsda_pkg::RATE_RST;
      sum        = '0;
      count      = '0;
      errors     = 0;
   endfunction

   function void write_reg(logic [adsda_pkg::CSR_ADDR_W-1:0] idx,
                           logic [adsda_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         adsda_pkg::REG_SAMPLE_SHIFT: shift = data[adsda_pkg::SHIFT_W-1:0];
         adsda_pkg::REG_ADC_MAX:      full_scale = data[adsda_pkg::ADC_W-1:0];
         adsda_pkg::REG_ADC_MIN:      offset = data[adsda_pkg::ADC_W-1:0];
         adsda_pkg::REG_DIG_POS:      dig_pos = data[adsda_pkg::SHIFT_W-1:0];
         adsda_pkg::REG_RATE:         rate = data[adsda_pkg::RATE_W-1:0];
         default: ;
      endcase
   endfunction

   function void take_sample(logic [adsda_pkg::SPI_W-1:0] word);
      logic [adsda_pkg::SPI_W-1:0]  raw;
      logic [adsda_pkg::SPI_W-1:0]  shifted;
      logic [adsda_pkg::ADC_W-1:0]  mask;
      logic [adsda_pkg::ADC_W-1:0]  level;
      logic [adsda_pkg::DIVR_W-1:0] window;
      logic [adsda_pkg::DIVR_W-1:0] next_count;
      logic [adsda_pkg::SUM_W-1:0]  quotient;
      average_beat_type             beat;
      int                           b;
      raw = swap_bytes(word);
      shifted = raw >> shift;
      for (b = 0; b < adsda_pkg::ADC_W; b++) mask[b] = |(full_scale >> b);
      level = shifted[adsda_pkg::ADC_W-1:0] & mask;
      level = (level < offset) ? '0 : level - offset;
      sum = sum + adsda_pkg::SUM_W'(level);
      window = (rate == '0) ? adsda_pkg::RATE_ZERO_WINDOW : adsda_pkg::DIVR_W'(rate);
      next_count = adsda_pkg::DIVR_W'(count) + 1'b1;
      if (next_count < window) begin
         count = next_count[adsda_pkg::RATE_W-1:0];
      end else begin
         quotient = sum / adsda_pkg::SUM_W'(window);
         beat.avg_value = (quotient > adsda_pkg::SUM_W'(adsda_pkg::AVG_MAX))
                          ? adsda_pkg::AVG_MAX : quotient[adsda_pkg::AVG_W-1:0];
         beat.dig_level = raw[dig_pos];
         expected_q.push_back(beat);
         sum = '0;
         count = '0;
      end
   endfunction

   function void check_average(logic [adsda_pkg::AVG_W-1:0] avg, logic dig);
      average_beat_type want;
      if (expected_q.size() == 0) begin
         errors++;
         $display("%0t: unexpected average beat, expected none, got %0d/%0d", $time, avg, dig);
      end else begin
         want = expected_q.pop_front();
         if (avg !== want.avg_value) begin
            errors++;
            $display("%0t: average_value expected %0d, got %0d", $time, want.avg_value, avg);
         end
         if (dig !== want.dig_level) begin
            errors++;
            $display("%0t: digital_level expected %0d, got %0d", $time, want.dig_level, dig);
         end
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module tb_adc_sample_decimating_averager;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int RANDOM_ITEMS  = 2000;

   logic clock = 1'b0;
   logic reset;
   int   sender_gap_pct;
   int   sink_stall_pct;
   int   cycle_count = 0;

   boxcar_tracker boxcar;

   adsda_req_if req_bus();
   adsda_rsp_if rsp_bus();
   adsda_csr_if csr_bus();

   adc_sample_decimating_averager dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         boxcar.check_average(rsp_bus.average_value, rsp_bus.digital_level);
   end

   task automatic send_sample(input logic [adsda_pkg::SPI_W-1:0] word);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.spi_word <= word;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      boxcar.take_sample(word);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (boxcar.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(input logic [adsda_pkg::CSR_ADDR_W-1:0] idx,
                          input logic [adsda_pkg::CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      boxcar.write_reg(idx, data);
   endtask

   task automatic write_settings(input logic [adsda_pkg::SHIFT_W-1:0] shift,
                                 input logic [adsda_pkg::ADC_W-1:0]   max_v,
                                 input logic [adsda_pkg::ADC_W-1:0]   min_v,
                                 input logic [adsda_pkg::SHIFT_W-1:0] dig,
                                 input logic [adsda_pkg::RATE_W-1:0]  rate);
      settle();
      set_reg(adsda_pkg::REG_SAMPLE_SHIFT, adsda_pkg::CSR_DATA_W'(shift));
      set_reg(adsda_pkg::REG_ADC_MAX, adsda_pkg::CSR_DATA_W'(max_v));
      set_reg(adsda_pkg::REG_ADC_MIN, adsda_pkg::CSR_DATA_W'(min_v));
      set_reg(adsda_pkg::REG_DIG_POS, adsda_pkg::CSR_DATA_W'(dig));
      set_reg(adsda_pkg::REG_RATE, rate);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      logic [adsda_pkg::SHIFT_W-1:0] shift_v;
      logic [adsda_pkg::SHIFT_W-1:0] dig_v;
      logic [adsda_pkg::ADC_W-1:0]   max_v;
      logic [adsda_pkg::ADC_W-1:0]   min_v;
      logic [adsda_pkg::RATE_W-1:0]  rate_v;
      logic [adsda_pkg::SPI_W-1:0]   raw;
      int                            roll;
      int                            burst;
      int                            sent;

      boxcar = new();
      sender_gap_pct = 24;
      sink_stall_pct = 64;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.spi_word <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.addr     <= adsda_pkg::REG_SAMPLE_SHIFT;
      csr_bus.data     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings, byte order and unsigned top byte
      send_sample(32'h0000_0000);
      send_sample(32'hFFFF_FFFF);
      send_sample(swap_bytes(32'h0102_0304));
      send_sample(32'h0000_00FF);

      write_settings(5'd31, 15'd32767, 15'd0, 5'd31, 16'd1);
      send_sample(swap_bytes(32'h8000_0000));
      send_sample(swap_bytes(32'h7FFF_FFFF));

      // empty mask
      write_settings(5'd0, 15'd0, 15'd0, 5'd0, 16'd1);
      send_sample(32'hFFFF_FFFF);
      send_sample(32'h1234_5678);

      // offset clamp
      write_settings(5'd0, 15'd32767, 15'd32767, 5'd15, 16'd1);
      send_sample(swap_bytes(32'h0000_7FFF));
      send_sample(swap_bytes(32'h0000_FFFE));
      write_settings(5'd0, 15'd32767, 15'd100, 5'd1, 16'd1);
      send_sample(swap_bytes(32'd50));
      send_sample(swap_bytes(32'd150));

      // rate lowered mid-window, average saturates
      write_settings(5'd0, 15'd32767, 15'd0, 5'd0, 16'd10);
      repeat (7) send_sample(swap_bytes(32'h0000_7FFF));
      write_settings(5'd0, 15'd32767, 15'd0, 5'd0, 16'd3);
      send_sample(swap_bytes(32'h0000_7FFF));

      // zero rate keeps the window open until a lower rate closes it
      write_settings(5'd0, 15'd32767, 15'd0, 5'd0, 16'd0);
      repeat (5) send_sample(swap_bytes(32'h0000_7FFF));
      write_settings(5'd0, 15'd32767, 15'd0, 5'd0, 16'd2);
      send_sample($urandom);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent < RANDOM_ITEMS / 3) begin
            sender_gap_pct = 24;
            sink_stall_pct = 64;
         end else if (sent < 2 * RANDOM_ITEMS / 3) begin
            sender_gap_pct = 64;
            sink_stall_pct = 24;
         end else begin
            sender_gap_pct = 0;
            sink_stall_pct = 0;
         end
         roll = $urandom_range(99);
         shift_v = (roll < 30) ? 5'd0 : (roll < 40) ? 5'd31
                   : adsda_pkg::SHIFT_W'($urandom_range(0, 17));
         roll = $urandom_range(99);
         max_v = (roll < 10) ? 15'd0 : (roll < 25) ? 15'd32767
                 : adsda_pkg::ADC_W'($urandom_range(0, 32767));
         roll = $urandom_range(99);
         min_v = (roll < 50) ? 15'd0 : (roll < 55) ? 15'd32767
                 : adsda_pkg::ADC_W'($urandom_range(0, 3000));
         roll = $urandom_range(99);
         dig_v = (roll < 15) ? 5'd0 : (roll < 30) ? 5'd31
                 : adsda_pkg::SHIFT_W'($urandom_range(0, 31));
         roll = $urandom_range(99);
         if (roll < 5)
            rate_v = 16'd0;
         else if (roll < 10)
            rate_v = 16'd65535;
         else if (roll < 15)
            rate_v = 16'd1;
         else if (roll < 75)
            rate_v = adsda_pkg::RATE_W'($urandom_range(2, 8));
         else
            rate_v = adsda_pkg::RATE_W'($urandom_range(9, 64));
         write_settings(shift_v, max_v, min_v, dig_v, rate_v);
         burst = $urandom_range(20, 80);
         repeat (burst) begin
            if ($urandom_range(99) < 25) begin
               raw = adsda_pkg::SPI_W'($urandom_range(0, 32767)) << shift_v;
               send_sample(swap_bytes(raw));
            end else begin
               send_sample($urandom);
            end
         end
         sent += burst;
      end

      settle();
      if (boxcar.errors == 0 && boxcar.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
